// ----- src/dpl_pkg.sv -----
// ----------------------------------------------------------------------------
// dpl_pkg: shared constants for the decimal period length block
// Result field width and the small constants of the digit arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package dpl_pkg;

  // width of the period_length result field
  localparam int unsigned PERIOD_BITS = 10;

  // radix of the expansion and the factors that never recur
  localparam int unsigned RADIX = 10;
  localparam int unsigned FIVE  = 5;

  // inverse of five modulo 2**32; its low bits give the inverse for any
  // narrower width, so exact division by five is one multiply
  localparam logic [31:0] FIVE_INV = 32'hCCCC_CCCD;

  // number of multiples of m held by the back end (1*m .. 9*m)
  localparam int unsigned NUM_MULT = RADIX - 1;

endpackage

`default_nettype wire

// ----- src/dpl_strip.sv -----
// ----------------------------------------------------------------------------
// dpl_strip: front end, removes factors of two and five
// Accepts one denominator, shifts out twos, divides out fives by reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module dpl_strip #(
  parameter int DENOM_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [DENOM_BITS-1:0] denominator,
  output logic                       q_push,
  input  wire logic                  q_full,
  output logic [DENOM_BITS-1:0]      q_data
);

  localparam longint unsigned       DMAX = (64'd1 << DENOM_BITS) - 64'd1;
  localparam logic [DENOM_BITS-1:0] INV5 = DENOM_BITS'(dpl_pkg::FIVE_INV);
  localparam logic [DENOM_BITS-1:0] LIM5 = DENOM_BITS'(DMAX / 64'(dpl_pkg::FIVE));

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_TWO  = 4'b0010,
    F_FIVE = 4'b0100,
    F_DONE = 4'b1000
  } front_state_t;

  front_state_t          state;
  logic [DENOM_BITS-1:0] val;
  logic [DENOM_BITS-1:0] prod;

  // exact quotient by five when val is a multiple of five; the product stays
  // at or below LIM5 exactly in that case
  assign prod = val * INV5;

  assign full   = (state != F_IDLE);
  assign q_push = (state == F_DONE);
  assign q_data = val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (push) begin
            val   <= denominator;
            state <= (denominator == '0) ? F_DONE : F_TWO;
          end
        end
        F_TWO: begin
          if (!val[0]) begin
            val <= val >> 1;
          end else begin
            state <= F_FIVE;
          end
        end
        F_FIVE: begin
          // divisible: keep quotient and try again, else done
          if (prod <= LIM5) begin
            val <= prod;
          end else begin
            state <= F_DONE;
          end
        end
        F_DONE: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/dpl_queue.sv -----
// ----------------------------------------------------------------------------
// dpl_queue: two-entry queue between front and back end
// Lets the stripping stage run ahead while the order search is busy.
// ----------------------------------------------------------------------------
`default_nettype none

module dpl_queue #(
  parameter int WIDTH = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       used;
  logic             do_push;
  logic             do_pop;

  assign full    = (used == 2'd2);
  assign empty   = (used == 2'd0);
  assign rdata   = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   used <= used + 2'd1;
        2'b01:   used <= used - 2'd1;
        default: used <= used;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/dpl_order.sv -----
// ----------------------------------------------------------------------------
// dpl_order: back end, multiplicative order of ten modulo m
// Builds 1*m..9*m, then steps r = 10*r mod m until the first remainder recurs.
// ----------------------------------------------------------------------------
`default_nettype none

module dpl_order #(
  parameter int DENOM_BITS = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_empty,
  output logic                               q_pop,
  input  wire logic [DENOM_BITS-1:0]         q_data,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [dpl_pkg::PERIOD_BITS-1:0]    period_length,
  output logic                               terminates
);

  localparam int XW = DENOM_BITS + 4;
  localparam int PB = dpl_pkg::PERIOD_BITS;
  localparam int CW = (DENOM_BITS > PB) ? DENOM_BITS : PB;
  localparam int NM = dpl_pkg::NUM_MULT;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MULT = 4'b0010,
    B_STEP = 4'b0100,
    B_DONE = 4'b1000
  } back_state_t;

  back_state_t           state;
  logic [DENOM_BITS-1:0] m;
  logic [XW-1:0]         acc;
  logic [XW-1:0]         mult [1:NM];
  logic [3:0]            mcnt;
  logic [DENOM_BITS-1:0] r;
  logic [DENOM_BITS-1:0] first;
  logic                  have_first;
  logic [CW-1:0]         count;
  logic                  term;

  logic                  res_valid;
  logic [PB-1:0]         res_period;
  logic                  res_term;

  logic [XW-1:0]         t;
  logic [XW-1:0]         sub;
  logic [XW-1:0]         nr_wide;
  logic [DENOM_BITS-1:0] nr;

  // 10*r, then subtract the largest multiple of m not above it
  always_comb begin
    t   = XW'({r, 3'b000}) + XW'({r, 1'b0});
    sub = '0;
    for (int j = 1; j <= NM; j++) begin
      if (t >= mult[j]) begin
        sub = mult[j];
      end
    end
    nr_wide = t - sub;
    nr      = nr_wide[DENOM_BITS-1:0];
  end

  assign q_pop         = (state == B_IDLE) && !q_empty;
  assign empty         = !res_valid;
  assign period_length = res_period;
  assign terminates    = res_term;

  always_ff @(posedge clk) begin
    if (state == B_MULT) begin
      for (int j = 1; j < NM; j++) begin
        mult[j] <= mult[j+1];
      end
      mult[NM] <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            m <= q_data;
            if (q_data <= DENOM_BITS'(1)) begin
              count <= '0;
              term  <= 1'b1;
              state <= B_DONE;
            end else begin
              acc        <= XW'(q_data);
              mcnt       <= '0;
              term       <= 1'b0;
              have_first <= 1'b0;
              r          <= DENOM_BITS'(1);
              state      <= B_MULT;
            end
          end
        end
        B_MULT: begin
          acc  <= acc + XW'(m);
          mcnt <= mcnt + 4'd1;
          if (mcnt == 4'(NM - 1)) begin
            state <= B_STEP;
          end
        end
        B_STEP: begin
          if (!have_first) begin
            first      <= nr;
            r          <= nr;
            count      <= CW'(1);
            have_first <= 1'b1;
          end else if (nr == first) begin
            state <= B_DONE;
          end else begin
            r     <= nr;
            count <= count + CW'(1);
          end
        end
        B_DONE: begin
          if (!res_valid) begin
            res_valid  <= 1'b1;
            res_period <= count[PB-1:0];
            res_term   <= term;
            state      <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/decimal_period_length.sv -----
// ----------------------------------------------------------------------------
// decimal_period_length: length of the recurring cycle of 1/d
// Strips twos and fives from d, then counts the order of ten modulo the rest.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake       fields
//   --------  ---------  --------------  ---------------------------------
//   request   in         push / full     denominator
//   result    out        pop / empty     period_length, terminates
//
// The front end shifts out factors of two, then divides out factors of five
// (exact division by a reciprocal multiply), then hands the result to the
// queue. The back end builds 1*m..9*m, then steps the remainder until the
// first one recurs; the remainder loop sets the rate. The two-entry queue
// lets the front end strip the next request while the back end searches.
// Reset (rst, synchronous) empties both ends and the queue. A result
// waiting on pop does not stop the back end from starting the next
// request; it only holds at the finish until the result is taken.
//
`default_nettype none

module decimal_period_length #(
  parameter int DENOM_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [DENOM_BITS-1:0]      denominator,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [dpl_pkg::PERIOD_BITS-1:0] period_length,
  output logic                            terminates
);

  // front end to queue
  logic                  f_push;
  logic                  f_full;
  logic [DENOM_BITS-1:0] f_data;

  // queue to back end
  logic                  b_pop;
  logic                  b_empty;
  logic [DENOM_BITS-1:0] b_data;

  // front: accept the request, strip twos and fives
  dpl_strip #(
    .DENOM_BITS (DENOM_BITS)
  ) u_strip (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .denominator (denominator),
    .q_push      (f_push),
    .q_full      (f_full),
    .q_data      (f_data)
  );

  // decouple the two ends
  dpl_queue #(
    .WIDTH (DENOM_BITS)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .full  (f_full),
    .wdata (f_data),
    .pop   (b_pop),
    .empty (b_empty),
    .rdata (b_data)
  );

  // back: step the remainder and hold the result for pop
  dpl_order #(
    .DENOM_BITS (DENOM_BITS)
  ) u_order (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (b_empty),
    .q_pop         (b_pop),
    .q_data        (b_data),
    .empty         (empty),
    .pop           (pop),
    .period_length (period_length),
    .terminates    (terminates)
  );

endmodule

`default_nettype wire

// ----- tb/tb_decimal_period_length.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_decimal_period_length: self-checking bench for decimal_period_length
// Sends denominators through the push/full side and predicts each recurring
// cycle length and terminates flag in the bench. Checks every result taken
// through empty/pop against the oldest prediction, with idle gaps on both
// sides.
// ----------------------------------------------------------------------------
module tb_decimal_period_length;

  localparam int DENOM_BITS       = 10;
  localparam int HALF_PERIOD      = 10;
  // Limit on cycles with no handshake. It must cover one full request, the
  // strip of twos and fives plus the back-end remainder search, and any
  // stall on pop, with a wide margin.
  localparam int WATCHDOG_LIMIT   = 20000;
  // Settle time after the last result. This covers one full remainder search,
  // so that any stray extra result still shows up.
  localparam int DRAIN_CYCLES     = 1200;
  localparam int MAX_REPORTS      = 10;
  localparam int RANDOM_PER_PHASE = 145;

  typedef struct packed {
    logic [dpl_pkg::PERIOD_BITS-1:0] period;
    logic                            terminates;
  } period_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            push = 1'b0;
  logic                            pop = 1'b0;
  logic [DENOM_BITS-1:0]           denominator = '0;
  logic                            full;
  logic                            empty;
  logic [dpl_pkg::PERIOD_BITS-1:0] period_length;
  logic                            terminates;

  // Predicted results, oldest first
  period_result_t expected_periods [$];
  int unsigned    failures = 0;
  int unsigned    idle_cycles = 0;
  // Idle odds in percent, set per phase: sender gaps and receiver stalls
  int unsigned    gap_pct = 0;
  int unsigned    stall_pct = 0;

  decimal_period_length #(
    .DENOM_BITS(DENOM_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .denominator  (denominator),
    .empty        (empty),
    .pop          (pop),
    .period_length(period_length),
    .terminates   (terminates)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Predict the result for one denominator. Strip twos and fives, then
  // count the steps r -> 10r mod m until the first remainder recurs.
  function automatic period_result_t decimal_period(input logic [DENOM_BITS-1:0] d);
    longint unsigned m;
    longint unsigned first;
    longint unsigned r;
    longint unsigned steps;
    period_result_t  res;
    m = 64'(d);
    while (m != 0 && m % 2 == 0) m = m / 2;
    while (m != 0 && m % dpl_pkg::FIVE == 0) m = m / dpl_pkg::FIVE;
    // Zero and pure products of twos and fives give a terminating expansion
    if (m <= 1) begin
      res.period     = '0;
      res.terminates = 1'b1;
      return res;
    end
    first = dpl_pkg::RADIX % m;
    r     = first;
    steps = 1;
    while (steps < m) begin
      r = (r * dpl_pkg::RADIX) % m;
      if (r == first) break;
      steps++;
    end
    res.period     = dpl_pkg::PERIOD_BITS'(steps);
    res.terminates = 1'b0;
    return res;
  endfunction

  // Count a failure. Print only the first few.
  task automatic report_failure(input string what, input period_result_t want,
                                input period_result_t got);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH %s: expected period %0d terminates %0b,",
               $realtime, what, want.period, want.terminates,
               " got period %0d terminates %0b", got.period, got.terminates);
    end
  endtask

  // Send one request. Hold push and data until full is low at an edge,
  // then record the prediction. Idle gaps come before the request.
  task automatic send_request(input logic [DENOM_BITS-1:0] d);
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    denominator <= d;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_periods.push_back(decimal_period(d));
  endtask

  // Drop push and wait until every predicted result has been taken.
  task automatic wait_for_results();
    push <= 1'b0;
    @(posedge clk);
    while (expected_periods.size() != 0) @(posedge clk);
  endtask

  // Random requests. Most are uniform over 1..1023. Some are small, for
  // quick turnaround. The rest are cores from 1 to 63 with a pile of twos and
  // fives, which work the stripping front end hard.
  task automatic run_random(input int unsigned count);
    int unsigned           pick;
    int unsigned           core;
    int unsigned           factor;
    logic [DENOM_BITS-1:0] d;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        d = DENOM_BITS'($urandom_range(1, 1023));
      end else if (pick < 85) begin
        d = DENOM_BITS'($urandom_range(1, 63));
      end else begin
        core = $urandom_range(1, 63);
        repeat ($urandom_range(1, 8)) begin
          factor = $urandom_range(1) ? 2 : dpl_pkg::FIVE;
          if (core * factor <= 1023) core = core * factor;
        end
        d = DENOM_BITS'(core);
      end
      send_request(d);
    end
    wait_for_results();
  endtask

  // Edge values: zero, one, pure twos and fives, both extremes of the field,
  // short and long cycles, and mixed denominators whose core is left after
  // the strip.
  task automatic test_directed_cases();
    logic [DENOM_BITS-1:0] picks [24];
    gap_pct   = 0;
    stall_pct = 0;
    picks = '{10'd0,   10'd1,   10'd2,   10'd5,   10'd10,  10'd1000,
              10'd512, 10'd625, 10'd3,   10'd7,   10'd9,   10'd11,
              10'd13,  10'd17,  10'd1023, 10'd983, 10'd1021, 10'd999,
              10'd640, 10'd768, 10'd875, 10'd1022, 10'd1008, 10'd997};
    foreach (picks[i]) send_request(picks[i]);
    wait_for_results();
  endtask

  // Back-to-back requests with pop held high
  task automatic test_back_to_back();
    gap_pct   = 0;
    stall_pct = 0;
    run_random(RANDOM_PER_PHASE);
  endtask

  // The sender idles in about half the cycles
  task automatic test_sender_gaps();
    gap_pct   = 53;
    stall_pct = 0;
    run_random(RANDOM_PER_PHASE);
  endtask

  // The receiver stalls in about half the cycles
  task automatic test_receiver_stalls();
    gap_pct   = 0;
    stall_pct = 53;
    run_random(RANDOM_PER_PHASE);
  endtask

  // Light idling on both sides at once
  task automatic test_both_sides_idle();
    gap_pct   = 9;
    stall_pct = 9;
    run_random(RANDOM_PER_PHASE);
  endtask

  // Receiver side: advance pop at random as the phase asks
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each result taken with the oldest prediction
  always @(posedge clk) begin : check_results
    period_result_t want;
    period_result_t got;
    if (!rst && pop && !empty) begin
      got.period     = period_length;
      got.terminates = terminates;
      if (expected_periods.size() == 0) begin
        report_failure("result with no request waiting", '0, got);
      end else begin
        want = expected_periods.pop_front();
        if (want.period !== got.period || want.terminates !== got.terminates) begin
          report_failure("result field", want, got);
        end
      end
    end
  end

  // Watchdog: end the run after too long with neither side moving a request
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] TIMEOUT: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();

    // Hold everything still for one full search so that a stray result shows
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
